// ===== rtl/tcpd_pkg.sv =====
// Shared types, constants and register map of the two-channel PWM dimmer.
package tcpd_pkg;

    localparam int LEVEL_BITS_DEF = 8;
    localparam int FIELD_W        = 8;
    localparam int BTN_W          = 4;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;

    localparam logic [FIELD_W-1:0] PERIOD_RST    = 8'd11;
    localparam logic [FIELD_W-1:0] MAX_LEVEL_RST = 8'd10;
    localparam logic [FIELD_W-1:0] MIN_LEVEL_RST = 8'd1;
    localparam int                 LEVEL_RST     = 2;

    // Button bit positions (active low on the pins).
    localparam int BTN_BLUE_UP = 0;
    localparam int BTN_BLUE_DN = 1;
    localparam int BTN_RED_UP  = 2;
    localparam int BTN_RED_DN  = 3;

    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_PWM    = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        REG_PERIOD    = 2'd0,
        REG_MAX_LEVEL = 2'd1,
        REG_MIN_LEVEL = 2'd2
    } reg_idx_t;

    typedef struct packed
    {
        logic [FIELD_W-1:0] period;
        logic [FIELD_W-1:0] max_level;
        logic [FIELD_W-1:0] min_level;
    } cfg_t;

    // Per-channel controls for one pipeline advance.
    typedef struct packed
    {
        logic advance;
        logic pwm_tick;
        logic held_up;
        logic held_dn;
    } chan_ctrl_t;

endpackage

// ===== rtl/two_channel_pwm_dimmer_top.sv =====
// Top level of the two-channel PWM LED dimmer with button control.
// Timing: the input register is loaded at the input transfer; the channel state registers
// (the result) and out_valid are loaded when the item advances, which out_stall can hold off.
// Throughput: one item per cycle while out_stall is low; a stalled result raises in_stall.
// Reset: asynchronous, active low; levels return to 2, phases to 0, pins on,
// buttons read as released and the registers take their default values.
module two_channel_pwm_dimmer_top
#(
    parameter int LEVEL_BITS = tcpd_pkg::LEVEL_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcpd_pkg::ADDR_W-1:0]      paddr,
    input  logic [tcpd_pkg::DATA_W-1:0]      pwdata,
    output logic [tcpd_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic [tcpd_pkg::BTN_W-1:0]       buttons,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             red_out,
    output logic                             blue_out,
    output logic [tcpd_pkg::FIELD_W-1:0]     red_level,
    output logic [tcpd_pkg::FIELD_W-1:0]     blue_level
);
    import tcpd_pkg::*;

    cfg_t               cfg;
    logic               in_vld_reg, in_vld_next;
    op_t                op_reg;
    logic [BTN_W-1:0]   btn_reg;
    logic [BTN_W-1:0]   prev_reg, prev_next;
    logic               out_vld_reg, out_vld_next;
    logic               advance;
    logic               in_take;
    logic [BTN_W-1:0]   held;
    chan_ctrl_t         red_ctrl, blue_ctrl;
    logic [LEVEL_BITS-1:0] red_lvl, blue_lvl;

    tcpd_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The item in the input register moves on once the result slot is free or taken.
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // A button counts as held when it reads low now and read low on the last sample.
    assign held = ~btn_reg & ~prev_reg;

    always_comb
    begin
        red_ctrl.advance  = advance;
        red_ctrl.pwm_tick = (op_reg == OP_PWM);
        red_ctrl.held_up  = held[BTN_RED_UP];
        red_ctrl.held_dn  = held[BTN_RED_DN];
        blue_ctrl.advance  = advance;
        blue_ctrl.pwm_tick = (op_reg == OP_PWM);
        blue_ctrl.held_up  = held[BTN_BLUE_UP];
        blue_ctrl.held_dn  = held[BTN_BLUE_DN];
    end

    tcpd_channel #(.LEVEL_BITS(LEVEL_BITS)) u_red
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .ctrl  (red_ctrl),
        .level (red_lvl),
        .pin   (red_out)
    );

    tcpd_channel #(.LEVEL_BITS(LEVEL_BITS)) u_blue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .ctrl  (blue_ctrl),
        .level (blue_lvl),
        .pin   (blue_out)
    );

    assign red_level  = FIELD_W'(red_lvl);
    assign blue_level = FIELD_W'(blue_lvl);
    assign out_valid  = out_vld_reg;

    always_comb
    begin
        in_vld_next  = in_take || (in_vld_reg && !advance);
        out_vld_next = advance || (out_vld_reg && out_stall);
        prev_next    = prev_reg;
        if (advance && (op_reg == OP_SAMPLE))
        begin
            prev_next = btn_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            prev_reg    <= '1;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            prev_reg    <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= op_t'(op);
            btn_reg <= buttons;
        end
    end

    // A PWM tick never changes a brightness level.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (op_reg == OP_PWM) |=> $stable(red_lvl) && $stable(blue_lvl))
        else $error("level changed on a PWM tick");

    // A button sample never changes the PWM pins.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (op_reg == OP_SAMPLE) |=> $stable(red_out) && $stable(blue_out))
        else $error("pin changed on a button sample");

    // Every advance produces a result transfer slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("advance without a result");

    // The channel state only moves when an item advances.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(red_lvl) && $stable(blue_lvl) && $stable(prev_reg))
        else $error("state changed without an item");

endmodule

// ===== rtl/tcpd_regs.sv =====
// Configuration register file behind the APB-style port.
module tcpd_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcpd_pkg::ADDR_W-1:0]     paddr,
    input  logic [tcpd_pkg::DATA_W-1:0]     pwdata,
    output logic [tcpd_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    output tcpd_pkg::cfg_t                  cfg
);
    import tcpd_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_PERIOD:    cfg_next.period    = pwdata[FIELD_W-1:0];
                REG_MAX_LEVEL: cfg_next.max_level = pwdata[FIELD_W-1:0];
                REG_MIN_LEVEL: cfg_next.min_level = pwdata[FIELD_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PERIOD:    prdata = DATA_W'(cfg_reg.period);
            REG_MAX_LEVEL: prdata = DATA_W'(cfg_reg.max_level);
            REG_MIN_LEVEL: prdata = DATA_W'(cfg_reg.min_level);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period    <= PERIOD_RST;
            cfg_reg.max_level <= MAX_LEVEL_RST;
            cfg_reg.min_level <= MIN_LEVEL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/tcpd_channel.sv =====
// One dimmer channel: brightness level, PWM phase counter and output pin.
module tcpd_channel
#(
    parameter int LEVEL_BITS = tcpd_pkg::LEVEL_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  tcpd_pkg::cfg_t               cfg,
    input  tcpd_pkg::chan_ctrl_t         ctrl,
    output logic [LEVEL_BITS-1:0]        level,
    output logic                         pin
);
    import tcpd_pkg::*;

    // Comparisons are made at the wider of the level and register widths.
    localparam int CMP_W = (LEVEL_BITS > FIELD_W) ? LEVEL_BITS : FIELD_W;

    logic [LEVEL_BITS-1:0] level_reg, level_next;
    logic [LEVEL_BITS-1:0] phase_reg, phase_next;
    logic                  pin_reg, pin_next;
    logic [LEVEL_BITS-1:0] level_up;
    logic [LEVEL_BITS-1:0] phase_inc;

    assign level = level_reg;
    assign pin   = pin_reg;

    always_comb
    begin
        level_next = level_reg;
        phase_next = phase_reg;
        pin_next   = pin_reg;
        level_up   = level_reg;
        phase_inc  = phase_reg + LEVEL_BITS'(1);

        if (ctrl.advance)
        begin
            if (ctrl.pwm_tick)
            begin
                phase_next = phase_inc;
                if (CMP_W'(phase_inc) >= CMP_W'(cfg.period))
                begin
                    phase_next = '0;
                    pin_next   = 1'b1;
                end
                if (CMP_W'(phase_next) > CMP_W'(level_reg))
                begin
                    pin_next = 1'b0;
                end
            end
            else
            begin
                // Up is tried first, then down, each against its own limit.
                if (ctrl.held_up && (CMP_W'(level_reg) < CMP_W'(cfg.max_level)))
                begin
                    level_up = level_reg + LEVEL_BITS'(1);
                end
                level_next = level_up;
                if (ctrl.held_dn && (CMP_W'(level_up) > CMP_W'(cfg.min_level)))
                begin
                    level_next = level_up - LEVEL_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= LEVEL_BITS'(LEVEL_RST);
            phase_reg <= '0;
            pin_reg   <= 1'b1;
        end
        else
        begin
            level_reg <= level_next;
            phase_reg <= phase_next;
            pin_reg   <= pin_next;
        end
    end

endmodule
